// ===== sv/array_list_insert_delete_defines.svh =====
// ----------------------------------------------------------------------------
// array_list_insert_delete_defines
// Assertion macros used by the array list sequencer.
// ----------------------------------------------------------------------------
`ifndef ARRAY_LIST_INSERT_DELETE_DEFINES_SVH
`define ARRAY_LIST_INSERT_DELETE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define ALID_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ALID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/alid_pkg.sv =====
// ----------------------------------------------------------------------------
// alid_pkg
// Types and constants for the positional array list.
// ----------------------------------------------------------------------------
package alid_pkg;

    // default list capacity
    localparam int ALID_DEPTH = 128;

    // word field widths
    localparam int DATA_W  = 32;
    localparam int POS_W   = 7;
    localparam int OP_W    = 3;
    localparam int COUNT_W = 8;

    // operation codes; code 7 is unused and acts as a no-op
    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_END   = 3'd4,
        OP_DEL_POS   = 3'd5,
        OP_READ      = 3'd6
    } op_t;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    // memory port strobes from the sequencer
    typedef struct packed {
        logic we;
        logic re;
    } mem_cmd_t;

endpackage

// ===== sv/alid_mem.sv =====
// ----------------------------------------------------------------------------
// alid_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module alid_mem
    import alid_pkg::*;
#(
    parameter int DEPTH = ALID_DEPTH,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic                     clk,
    input  mem_cmd_t                 cmd,
    input  logic [AW-1:0]            waddr,
    input  logic signed [DATA_W-1:0] wdata,
    input  logic [AW-1:0]            raddr,
    output logic signed [DATA_W-1:0] rdata
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered; data holds while re is low
    always_ff @(posedge clk)
    begin
        if (cmd.re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/alid_ctrl.sv =====
// ----------------------------------------------------------------------------
// alid_ctrl
// Sequencer: checks each command word, moves entries through the store one
// per cycle, and registers the result word.
// ----------------------------------------------------------------------------
`include "array_list_insert_delete_defines.svh"

module alid_ctrl
    import alid_pkg::*;
#(
    parameter int DEPTH = ALID_DEPTH,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [OP_W-1:0]           operation,
    input  logic [POS_W-1:0]          position,
    input  logic signed [DATA_W-1:0]  item_value,
    output logic                      done,
    output logic [1:0]                status,
    output logic signed [DATA_W-1:0]  read_value,
    output logic [COUNT_W-1:0]        entry_count,
    output mem_cmd_t                  mem_cmd,
    output logic [AW-1:0]             mem_waddr,
    output logic signed [DATA_W-1:0]  mem_wdata,
    output logic [AW-1:0]             mem_raddr,
    input  logic signed [DATA_W-1:0]  mem_rdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SHIFT,
        S_INS_PUT,
        S_DEL_SHIFT,
        S_RD_WAIT
    } state_t;

    state_t                   state_reg,  state_next;
    logic [CW-1:0]            count_reg,  count_next;
    logic [AW-1:0]            idx_reg,    idx_next;
    logic [AW-1:0]            at_reg,     at_next;
    logic signed [DATA_W-1:0] val_reg,    val_next;
    logic                     done_reg,   done_next;
    status_t                  status_reg, status_next;
    logic signed [DATA_W-1:0] rdv_reg,    rdv_next;

    op_t           op;
    logic [PW-1:0] cnt_x;
    logic [PW-1:0] pos_x;
    logic [PW-1:0] at_x;
    logic [AW-1:0] cnt_m1;
    logic          is_ins;
    logic          is_del;
    logic          is_rd;
    status_t       chk_st;

    assign op     = op_t'(operation);
    assign cnt_x  = PW'(count_reg);
    assign pos_x  = PW'(position);
    assign cnt_m1 = AW'(count_reg - CW'(1));

    // command decode and checks
    always_comb
    begin
        is_ins = 1'b0;
        is_del = 1'b0;
        is_rd  = 1'b0;
        at_x   = '0;
        chk_st = ST_OK;
        unique case (op) inside
            OP_INS_FRONT, OP_INS_END, OP_INS_POS:
            begin
                is_ins = 1'b1;
                if (op == OP_INS_END)
                begin
                    at_x = cnt_x;
                end
                else if (op == OP_INS_POS)
                begin
                    at_x = pos_x;
                end
                if (count_reg == CW'(DEPTH))
                begin
                    chk_st = ST_FULL;
                end
                else if (at_x > cnt_x)
                begin
                    chk_st = ST_BADPOS;
                end
            end
            OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS:
            begin
                is_del = 1'b1;
                if (op == OP_DEL_END)
                begin
                    at_x = cnt_x - PW'(1);
                end
                else if (op == OP_DEL_POS)
                begin
                    at_x = pos_x;
                end
                if (count_reg == '0)
                begin
                    chk_st = ST_EMPTY;
                end
                else if (at_x >= cnt_x)
                begin
                    chk_st = ST_BADPOS;
                end
            end
            OP_READ:
            begin
                is_rd = 1'b1;
                if (count_reg == '0)
                begin
                    chk_st = ST_EMPTY;
                end
                else if (pos_x >= cnt_x)
                begin
                    chk_st = ST_BADPOS;
                end
            end
            default:
            begin
                chk_st = ST_OK;
            end
        endcase
    end

    // next state, memory requests and result word
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        at_next     = at_reg;
        val_next    = val_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        rdv_next    = rdv_reg;
        mem_cmd     = '0;
        mem_waddr   = '0;
        mem_wdata   = val_reg;
        mem_raddr   = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = chk_st;
                    rdv_next    = '0;
                    val_next    = item_value;
                    at_next     = AW'(at_x);
                    if (chk_st != ST_OK)
                    begin
                        done_next = 1'b1;
                    end
                    else if (is_rd)
                    begin
                        mem_cmd.re = 1'b1;
                        mem_raddr  = AW'(position);
                        state_next = S_RD_WAIT;
                    end
                    else if (is_ins)
                    begin
                        if (at_x < cnt_x)
                        begin
                            // open a gap: move the tail up, last entry first
                            mem_cmd.re = 1'b1;
                            mem_raddr  = cnt_m1;
                            idx_next   = cnt_m1;
                            state_next = S_INS_SHIFT;
                        end
                        else
                        begin
                            // append, nothing to move
                            mem_cmd.we = 1'b1;
                            mem_waddr  = AW'(at_x);
                            mem_wdata  = item_value;
                            count_next = count_reg + CW'(1);
                            done_next  = 1'b1;
                        end
                    end
                    else if (is_del)
                    begin
                        if (at_x + PW'(1) < cnt_x)
                        begin
                            // close the gap: move the tail down, first entry first
                            mem_cmd.re = 1'b1;
                            mem_raddr  = AW'(at_x + PW'(1));
                            idx_next   = AW'(at_x + PW'(1));
                            state_next = S_DEL_SHIFT;
                        end
                        else
                        begin
                            // last entry removed, nothing to move
                            count_next = count_reg - CW'(1);
                            done_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            S_INS_SHIFT:
            begin
                mem_cmd.we = 1'b1;
                mem_waddr  = idx_reg + AW'(1);
                mem_wdata  = mem_rdata;
                if (idx_reg == at_reg)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    mem_cmd.re = 1'b1;
                    mem_raddr  = idx_reg - AW'(1);
                    idx_next   = idx_reg - AW'(1);
                end
            end
            S_INS_PUT:
            begin
                mem_cmd.we = 1'b1;
                mem_waddr  = at_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_DEL_SHIFT:
            begin
                mem_cmd.we = 1'b1;
                mem_waddr  = idx_reg - AW'(1);
                mem_wdata  = mem_rdata;
                if (idx_reg == cnt_m1)
                begin
                    count_next = count_reg - CW'(1);
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    mem_cmd.re = 1'b1;
                    mem_raddr  = idx_reg + AW'(1);
                    idx_next   = idx_reg + AW'(1);
                end
            end
            S_RD_WAIT:
            begin
                rdv_next   = mem_rdata;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            at_reg     <= '0;
            val_reg    <= '0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            rdv_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            at_reg     <= at_next;
            val_reg    <= val_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            rdv_reg    <= rdv_next;
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign read_value  = rdv_reg;
    assign entry_count = COUNT_W'(count_reg);

    // checks
    `ALID_ASSERT_IMPL(a_count_max, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH), "count above depth")
    `ALID_ASSERT_IMPL(a_no_rw_clash, clk, rst_n, mem_cmd.we && mem_cmd.re, mem_waddr != mem_raddr, "read and write hit one entry")
    `ALID_ASSERT_IMPL(a_done_idle, clk, rst_n, done_reg, state_reg == S_IDLE, "result while still busy")
    `ALID_ASSERT_NEXT(a_count_done, clk, rst_n, count_next != count_reg, done_reg, "count changed without result")

endmodule

// ===== sv/array_list_insert_delete.sv =====
// A rejected command, append or tail delete is answered straight from idle; a read goes through S_RD_WAIT.
// An insert moves entries in S_INS_SHIFT, then writes the new entry in S_INS_PUT; a delete moves them in S_DEL_SHIFT.
// The store moves one entry per cycle; no new word is taken while busy.
// busy is low again in the cycle the result shows; done pulses once and cannot be stalled.
// Reset clears the count and the result registers; store contents are left as they are, no clearing pass.
// ----------------------------------------------------------------------------
// array_list_insert_delete
// Ordered list of signed 32-bit entries with positional insert, delete and read.
// ----------------------------------------------------------------------------
module array_list_insert_delete
    import alid_pkg::*;
#(
    parameter int DEPTH = ALID_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [OP_W-1:0]           operation,
    input  logic [POS_W-1:0]          position,
    input  logic signed [DATA_W-1:0]  item_value,
    output logic                      done,
    output logic [1:0]                status,
    output logic signed [DATA_W-1:0]  read_value,
    output logic [COUNT_W-1:0]        entry_count
);

    localparam int AW = $clog2(DEPTH);

    mem_cmd_t                 mem_cmd;
    logic [AW-1:0]            mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic signed [DATA_W-1:0] mem_rdata;

    // sequencer
    alid_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .position    (position),
        .item_value  (item_value),
        .done        (done),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count),
        .mem_cmd     (mem_cmd),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    // entry store
    alid_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .cmd   (mem_cmd),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the positional array list. Commands are driven
// through the start/busy handshake; a shadow list predicts status, read
// value and count for each accepted command, and every done strobe is
// checked against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import alid_pkg::*;

    localparam int                 STALL_LIMIT = 4000;
    localparam int                 PHASE_WORDS = 630;
    localparam logic [OP_W-1:0]    OP_NONE     = 3'd7;

    // shadow copy of the list, predicts one answer per command
    class array_list_predictor;
        typedef struct {
            status_t                   st;
            logic signed [DATA_W-1:0]  rd;
            logic [COUNT_W-1:0]        cnt;
        } answer_t;

        logic signed [DATA_W-1:0]  list_entries [ALID_DEPTH];
        int unsigned               list_len;
        answer_t                   answers_due [$];
        int unsigned               failures;

        function new();
            list_len = 0;
            failures = 0;
        endfunction

        function status_t insert_at(int unsigned at, logic signed [DATA_W-1:0] v);
            int unsigned i;
            if (list_len >= ALID_DEPTH)
                return ST_FULL;
            if (at > list_len)
                return ST_BADPOS;
            for (i = list_len; i > at; i--)
                list_entries[i] = list_entries[i-1];
            list_entries[at] = v;
            list_len++;
            return ST_OK;
        endfunction

        function status_t delete_at(int unsigned at);
            int unsigned i;
            if (list_len == 0)
                return ST_EMPTY;
            if (at >= list_len)
                return ST_BADPOS;
            for (i = at; i + 1 < list_len; i++)
                list_entries[i] = list_entries[i+1];
            list_len--;
            return ST_OK;
        endfunction

        // apply an accepted command and queue its answer
        function void note_command(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                   logic signed [DATA_W-1:0] val);
            answer_t a;
            a.st = ST_OK;
            a.rd = '0;
            case (op)
                OP_INS_FRONT: a.st = insert_at(0, val);
                OP_INS_END:   a.st = insert_at(list_len, val);
                OP_INS_POS:   a.st = insert_at(pos, val);
                OP_DEL_FRONT: a.st = delete_at(0);
                OP_DEL_END:   a.st = delete_at(list_len == 0 ? 0 : list_len - 1);
                OP_DEL_POS:   a.st = delete_at(pos);
                OP_READ:
                begin
                    if (list_len == 0)
                        a.st = ST_EMPTY;
                    else if (pos >= list_len)
                        a.st = ST_BADPOS;
                    else
                        a.rd = list_entries[pos];
                end
                default: ;
            endcase
            a.cnt = list_len[COUNT_W-1:0];
            answers_due.push_back(a);
        endfunction

        function void fail_note(string what);
            failures++;
            if (failures <= 10)
                $display("%0t mismatch: %s", $realtime, what);
        endfunction

        // compare one done word with the oldest answer
        function void check_answer(logic [1:0] st, logic signed [DATA_W-1:0] rd,
                                   logic [COUNT_W-1:0] cnt);
            answer_t a;
            if (answers_due.size() == 0)
            begin
                fail_note($sformatf("done with nothing outstanding (status %0d)", st));
                return;
            end
            a = answers_due.pop_front();
            if (st !== a.st || rd !== a.rd || cnt !== a.cnt)
                fail_note($sformatf("status %0d/%0d read_value %0d/%0d count %0d/%0d (exp/act)",
                                    a.st, st, a.rd, rd, a.cnt, cnt));
        endfunction

        function int outstanding();
            return answers_due.size();
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n      = 1'b0;
    logic                      start      = 1'b0;
    logic [OP_W-1:0]           operation  = '0;
    logic [POS_W-1:0]          position   = '0;
    logic signed [DATA_W-1:0]  item_value = '0;
    logic                      busy;
    logic                      done;
    logic [1:0]                status;
    logic signed [DATA_W-1:0]  read_value;
    logic [COUNT_W-1:0]        entry_count;

    array_list_predictor  shadow = new();
    int                   idle_pct;
    bit                   filling = 1'b1;

    array_list_insert_delete dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .position    (position),
        .item_value  (item_value),
        .done        (done),
        .status      (status),
        .read_value  (read_value),
        .entry_count (entry_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            shadow.check_answer(status, read_value, entry_count);
    end

    // watchdog: cycles with neither an accepted command nor a result
    initial
    begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((start && !busy) || done))
                stall = 0;
            else
                stall++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // drive one command word, with an optional idle gap ahead of it
    task automatic send_word(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                             input logic signed [DATA_W-1:0] val);
        int gap;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(ALID_DEPTH + 20, 4)
                                           : $urandom_range(3, 1);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start      <= 1'b1;
        operation  <= op;
        position   <= pos;
        item_value <= val;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        shadow.note_command(op, pos, val);
    endtask

    // hold off until every outstanding answer is in
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (shadow.outstanding() != 0)
            @(posedge clk);
    endtask

    function automatic logic [OP_W-1:0] any_insert();
        case ($urandom_range(2))
            0:       return OP_INS_FRONT;
            1:       return OP_INS_END;
            default: return OP_INS_POS;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] any_delete();
        case ($urandom_range(2))
            0:       return OP_DEL_FRONT;
            1:       return OP_DEL_END;
            default: return OP_DEL_POS;
        endcase
    endfunction

    // positions cluster around the live range and its edges
    function automatic logic [POS_W-1:0] pick_pos(int len);
        int p;
        int r;
        r = $urandom_range(99);
        if (r < 55)
            p = $urandom_range(len, 0);
        else if (r < 70)
            p = len;
        else if (r < 80)
            p = len - 1;
        else
            p = $urandom_range(127);
        return p[POS_W-1:0];
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // random word; alternates between growing to full and shrinking to empty
    task automatic random_word();
        logic [OP_W-1:0] op;
        int              r;
        r = $urandom_range(99);
        if (filling)
            op = (r < 70) ? any_insert() : (r < 85) ? OP_READ : (r < 96) ? any_delete() : OP_NONE;
        else
            op = (r < 70) ? any_delete() : (r < 85) ? OP_READ : (r < 96) ? any_insert() : OP_NONE;
        send_word(op, pick_pos(shadow.list_len), pick_value());
        if (filling && shadow.list_len == ALID_DEPTH && $urandom_range(5) == 0)
            filling = 1'b0;
        else if (!filling && shadow.list_len == 0 && $urandom_range(5) == 0)
            filling = 1'b1;
        else if ($urandom_range(199) == 0)
            filling = !filling;
        if ($urandom_range(99) == 0)
            drain();
    endtask

    // main sequence
    initial
    begin
        idle_pct = 17;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // empty list: read, every delete, insert past the end, unused code
        send_word(OP_READ,      7'd0,   32'sd5);
        send_word(OP_DEL_FRONT, 7'd0,   32'sd0);
        send_word(OP_DEL_END,   7'd0,   32'sd0);
        send_word(OP_DEL_POS,   7'd127, 32'sd0);
        send_word(OP_INS_POS,   7'd1,   32'sd9);
        send_word(OP_NONE,      7'd0,   32'sd0);
        // build a short list with extreme values
        send_word(OP_INS_END,   7'd0,   32'h7FFF_FFFF);
        send_word(OP_INS_FRONT, 7'd0,   32'h8000_0000);
        send_word(OP_INS_POS,   7'd2,   32'hFFFF_FFFF);
        send_word(OP_INS_POS,   7'd1,   32'h0000_0000);
        send_word(OP_INS_POS,   7'd127, 32'h1234_5678);
        send_word(OP_READ,      7'd0,   32'sd0);
        send_word(OP_READ,      7'd1,   32'sd0);
        send_word(OP_READ,      7'd2,   32'sd0);
        send_word(OP_READ,      7'd3,   32'sd0);
        // reads and deletes at or past the count, then valid deletes and a read
        send_word(OP_READ,      7'd4,   32'sd0);
        send_word(OP_READ,      7'd127, 32'sd0);
        send_word(OP_DEL_POS,   7'd4,   32'sd0);
        send_word(OP_DEL_POS,   7'd1,   32'sd0);
        send_word(OP_DEL_END,   7'd0,   32'sd0);
        send_word(OP_DEL_FRONT, 7'd0,   32'sd0);
        send_word(OP_READ,      7'd0,   32'sd0);
        send_word(OP_NONE,      7'd127, 32'hFFFF_FFFF);

        // random phases: light sender idling, heavy idling, none
        for (int phase = 0; phase < 3; phase++)
        begin
            drain();
            idle_pct = (phase == 0) ? 17 : (phase == 1) ? 62 : 0;
            repeat (PHASE_WORDS) random_word();
        end

        drain();
        repeat (ALID_DEPTH + 8) @(posedge clk);
        if (shadow.failures == 0 && shadow.outstanding() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
